FILE: rtl/cman_pkg.sv
// Shared types and constants for the centred moving-average normaliser.
// Holds the item structs, state enums and register indexes.
// No dependencies; every other file in rtl/ imports this package.
package cman_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int CFG_BITS     = 12;
    localparam int LEVEL_BITS   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int CFG_IDX_BITS = 4;
    localparam int WINDOW_DEF   = 16;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int NRM_N_W_DEF   = $clog2(WINDOW_DEF + 1);
    localparam int NRM_SUM_W_DEF = SAMPLE_BITS + NRM_N_W_DEF;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXT_LOW  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXT_HIGH = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLX_LOW  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLX_HIGH = CFG_IDX_BITS'(3);

    localparam logic [CFG_BITS-1:0] EXT_LOW_RST  = CFG_BITS'(0);
    localparam logic [CFG_BITS-1:0] EXT_HIGH_RST = CFG_BITS'(1);
    localparam logic [CFG_BITS-1:0] FLX_LOW_RST  = CFG_BITS'(17);
    localparam logic [CFG_BITS-1:0] FLX_HIGH_RST = CFG_BITS'(49);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] ext_mag;
        logic [SAMPLE_BITS-1:0] flx_mag;
        logic                   record_end;
    } cman_in_t;

    typedef struct packed {
        logic signed [LEVEL_BITS-1:0] ext_level;
        logic signed [LEVEL_BITS-1:0] flx_level;
        logic                         final_out;
    } cman_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CALC,
        ST_WAIT,
        ST_TRD,
        ST_TSUB
    } cman_state_t;

    typedef enum logic [2:0] {
        NRM_IDLE,
        NRM_MUL,
        NRM_PREP,
        NRM_DIV,
        NRM_FIN
    } nrm_state_t;

endpackage

FILE: rtl/centered_moving_average_norm.sv
// An accepted item is stored and summed, then both channels are normalised by a shift-add
// multiply and a one-bit-a-cycle restoring divider before the result is registered.
// A new item is taken only once the last one is through; an item with no result returns
// straight to idle, a record end adds tail results, and a stalled result port holds the
// block until it drains.
// Synchronous active-low reset clears sums, counts and configuration registers to their
// reset values; the history memory and the payload registers are not cleared.
module centered_moving_average_norm
    import cman_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  cman_in_t                s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output cman_out_t               m_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    localparam int N_W    = $clog2(WINDOW + 1);
    localparam int ADDR_W = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + N_W;
    localparam int MEM_W  = 2 * SAMPLE_BITS;

    localparam logic [N_W-1:0]    WIN_N     = N_W'(WINDOW);
    localparam logic [N_W-1:0]    HALF_N    = N_W'(WINDOW / 2);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW - 1);
    localparam logic [ADDR_W:0]   WIN_A     = (ADDR_W + 1)'(WINDOW);
    localparam logic [ADDR_W-1:0] TAIL_LAST = ADDR_W'(WINDOW / 2 - 2);

    cman_state_t state_reg, state_next;

    cman_in_t              in_reg;
    logic [N_W-1:0]        fill_reg, n_reg;
    logic [ADDR_W-1:0]     oldest_reg, tail_reg;
    logic [SUM_W-1:0]      ext_sum_reg, flx_sum_reg;
    logic                  final_reg;
    cman_out_t             out_reg;
    logic                  m_valid_reg;
    logic [CFG_BITS-1:0]   ext_low_reg, ext_high_reg, flx_low_reg, flx_high_reg;

    logic [MEM_W-1:0]      hist_mem [WINDOW];
    logic [MEM_W-1:0]      rd_data_reg;

    logic                  full, short_end, emit_upd;
    logic [N_W-1:0]        fill_inc;
    logic [ADDR_W:0]       tail_sum;
    logic [ADDR_W-1:0]     tail_addr, rd_addr, mem_waddr;
    logic [SAMPLE_BITS-1:0] old_ext, old_flx;
    logic                  s_ready_c, mem_we, norm_start, load_out;
    logic                  ext_done, flx_done, norm_done;
    logic signed [LEVEL_BITS-1:0] ext_level, flx_level;

    always_comb begin
        full      = (fill_reg == WIN_N);
        fill_inc  = fill_reg + 1'b1;
        // record ends before the window has filled: one result only
        short_end = !full && in_reg.record_end && (fill_inc != WIN_N);
        emit_upd  = full || short_end || (fill_inc >= HALF_N);
        tail_sum  = {1'b0, oldest_reg} + {1'b0, tail_reg};
        tail_addr = (tail_sum >= WIN_A) ? ADDR_W'(tail_sum - WIN_A) : tail_sum[ADDR_W-1:0];
        old_ext   = rd_data_reg[MEM_W-1:SAMPLE_BITS];
        old_flx   = rd_data_reg[SAMPLE_BITS-1:0];
        norm_done = ext_done & flx_done;
        mem_waddr = full ? oldest_reg : fill_reg[ADDR_W-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_UPDATE;
            ST_UPDATE: state_next = emit_upd ? ST_CALC : ST_IDLE;
            ST_CALC:   state_next = ST_WAIT;
            ST_WAIT: begin
                if (load_out) begin
                    if (final_reg) state_next = ST_IDLE;
                    else if (in_reg.record_end) state_next = ST_TRD;
                    else state_next = ST_IDLE;
                end
            end
            ST_TRD:    state_next = ST_TSUB;
            ST_TSUB:   state_next = ST_CALC;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready_c  = 1'b0;
        mem_we     = 1'b0;
        norm_start = 1'b0;
        load_out   = 1'b0;
        rd_addr    = oldest_reg;
        unique case (state_reg)
            ST_IDLE:   s_ready_c  = 1'b1;
            ST_UPDATE: mem_we     = 1'b1;
            ST_CALC:   norm_start = 1'b1;
            ST_WAIT:   load_out   = norm_done && (!m_valid_reg || m_ready);
            ST_TRD:    rd_addr    = tail_addr;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            oldest_reg   <= '0;
            tail_reg     <= '0;
            ext_sum_reg  <= '0;
            flx_sum_reg  <= '0;
            final_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            ext_low_reg  <= EXT_LOW_RST;
            ext_high_reg <= EXT_HIGH_RST;
            flx_low_reg  <= FLX_LOW_RST;
            flx_high_reg <= FLX_HIGH_RST;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_EXT_LOW:  ext_low_reg  <= cfg_data;
                    CFG_EXT_HIGH: ext_high_reg <= cfg_data;
                    CFG_FLX_LOW:  flx_low_reg  <= cfg_data;
                    CFG_FLX_HIGH: flx_high_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (s_valid && s_ready_c) begin
                tail_reg <= '0;
            end

            if (state_reg == ST_UPDATE) begin
                if (full) begin
                    ext_sum_reg <= ext_sum_reg + SUM_W'(in_reg.ext_mag) - SUM_W'(old_ext);
                    flx_sum_reg <= flx_sum_reg + SUM_W'(in_reg.flx_mag) - SUM_W'(old_flx);
                    oldest_reg  <= (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + 1'b1;
                end else begin
                    ext_sum_reg <= ext_sum_reg + SUM_W'(in_reg.ext_mag);
                    flx_sum_reg <= flx_sum_reg + SUM_W'(in_reg.flx_mag);
                    fill_reg    <= fill_inc;
                end
                final_reg <= short_end;
            end

            // tail: drop the oldest remaining sample
            if (state_reg == ST_TSUB) begin
                ext_sum_reg <= ext_sum_reg - SUM_W'(old_ext);
                flx_sum_reg <= flx_sum_reg - SUM_W'(old_flx);
                final_reg   <= (tail_reg == TAIL_LAST);
                tail_reg    <= tail_reg + 1'b1;
            end

            if (load_out && final_reg) begin
                ext_sum_reg <= '0;
                flx_sum_reg <= '0;
                fill_reg    <= '0;
                oldest_reg  <= '0;
            end

            m_valid_reg <= load_out | (m_valid_reg & ~m_ready);
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready_c) begin
            in_reg <= s_data;
        end
        if (state_reg == ST_UPDATE) begin
            n_reg <= full ? WIN_N : fill_inc;
        end
        if (state_reg == ST_TSUB) begin
            n_reg <= WIN_N - N_W'(tail_reg) - 1'b1;
        end
        if (load_out) begin
            out_reg.ext_level <= ext_level;
            out_reg.flx_level <= flx_level;
            out_reg.final_out <= final_reg;
        end
    end

    // sample history, both channels side by side
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[mem_waddr] <= {in_reg.ext_mag, in_reg.flx_mag};
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= hist_mem[rd_addr];
    end

    cman_norm #(
        .N_W   (N_W),
        .SUM_W (SUM_W)
    ) u_ext_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .sum     (ext_sum_reg),
        .n       (n_reg),
        .lo      (ext_low_reg),
        .hi      (ext_high_reg),
        .done    (ext_done),
        .level   (ext_level)
    );

    cman_norm #(
        .N_W   (N_W),
        .SUM_W (SUM_W)
    ) u_flx_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .sum     (flx_sum_reg),
        .n       (n_reg),
        .lo      (flx_low_reg),
        .hi      (flx_high_reg),
        .done    (flx_done),
        .level   (flx_level)
    );

    assign s_ready   = s_ready_c;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= WIN_N)
        else $error("fill count beyond window");

    a_record_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && final_reg) |=>
            (fill_reg == '0 && ext_sum_reg == '0 && flx_sum_reg == '0))
        else $error("record state not cleared after final item");

    a_norm_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        ext_done == flx_done)
        else $error("channel normalisers out of step");

    a_norm_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |=> !norm_done)
        else $error("stale normaliser result after start");

endmodule

FILE: rtl/cman_norm.sv
// Bit-serial normaliser: trunc(256*(sum - lo*n) / (n*(hi-lo))), saturated to Q8.8.
// Shift-add multiply over the bits of n, then restoring division one quotient bit a cycle.
// Depends on cman_pkg.
module cman_norm
    import cman_pkg::*;
#(
    parameter int N_W   = NRM_N_W_DEF,
    parameter int SUM_W = NRM_SUM_W_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [SUM_W-1:0]             sum,
    input  logic [N_W-1:0]               n,
    input  logic [CFG_BITS-1:0]          lo,
    input  logic [CFG_BITS-1:0]          hi,
    output logic                         done,
    output logic signed [LEVEL_BITS-1:0] level
);

    localparam int LON_W = CFG_BITS + N_W;
    localparam int MAG_W = max_int(SUM_W, LON_W);
    localparam int A_W   = MAG_W + FRAC_BITS;
    localparam int CNT_W = $clog2(A_W + 1);

    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(N_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(A_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(1);
    localparam logic [LEVEL_BITS-1:0] POS_SAT = {1'b0, {(LEVEL_BITS-1){1'b1}}};
    localparam logic [LEVEL_BITS-1:0] NEG_SAT = {1'b1, {(LEVEL_BITS-1){1'b0}}};

    nrm_state_t state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [N_W-1:0]        n_sh_reg;
    logic [LON_W-1:0]      lo_sh_reg, rng_sh_reg, acc_reg, den_reg, rem_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic                  bad_reg, neg_reg, ovf_reg;
    logic [A_W-1:0]        a_reg;
    logic [LEVEL_BITS-1:0] q_reg;
    logic signed [LEVEL_BITS-1:0] level_reg;

    logic                  mul_en, prep_en, div_en, fin_en;
    logic [MAG_W:0]        diff, neg_diff;
    logic [MAG_W-1:0]      mag;
    logic [LON_W:0]        trial, den_ext, sub;
    logic                  ge;
    logic [LON_W-1:0]      rem_next;
    logic                  sat;
    logic [LEVEL_BITS-1:0] level_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            NRM_IDLE: if (start) state_next = NRM_MUL;
            NRM_MUL:  if (cnt_reg == LAST_STEP) state_next = NRM_PREP;
            NRM_PREP: state_next = NRM_DIV;
            NRM_DIV:  if (cnt_reg == LAST_STEP) state_next = NRM_FIN;
            NRM_FIN:  state_next = NRM_IDLE;
            default:  state_next = NRM_IDLE;
        endcase
    end

    // step enables
    always_comb begin
        mul_en  = 1'b0;
        prep_en = 1'b0;
        div_en  = 1'b0;
        fin_en  = 1'b0;
        unique case (state_reg)
            NRM_MUL:  mul_en  = 1'b1;
            NRM_PREP: prep_en = 1'b1;
            NRM_DIV:  div_en  = 1'b1;
            NRM_FIN:  fin_en  = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        diff     = {1'b0, MAG_W'(sum_reg)} - {1'b0, MAG_W'(acc_reg)};
        neg_diff = ~diff + 1'b1;
        mag      = diff[MAG_W] ? neg_diff[MAG_W-1:0] : diff[MAG_W-1:0];

        trial    = {rem_reg, a_reg[A_W-1]};
        den_ext  = {1'b0, den_reg};
        ge       = (trial >= den_ext);
        sub      = trial - den_ext;
        rem_next = ge ? sub[LON_W-1:0] : trial[LON_W-1:0];

        // quotient of 2^15 or more no longer fits the positive range
        sat = ovf_reg | q_reg[LEVEL_BITS-1];
        if (bad_reg) begin
            level_next = POS_SAT;
        end else if (neg_reg) begin
            level_next = sat ? NEG_SAT : (~q_reg + 1'b1);
        end else begin
            level_next = sat ? POS_SAT : q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= NRM_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (start) begin
                done_reg <= 1'b0;
                cnt_reg  <= MUL_STEPS;
            end else if (mul_en || div_en) begin
                cnt_reg <= cnt_reg - 1'b1;
            end else if (prep_en) begin
                cnt_reg <= DIV_STEPS;
            end else if (fin_en) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_sh_reg   <= n;
            lo_sh_reg  <= LON_W'(lo);
            rng_sh_reg <= LON_W'(hi - lo);
            acc_reg    <= '0;
            den_reg    <= '0;
            sum_reg    <= sum;
            bad_reg    <= (hi <= lo);
        end
        if (mul_en) begin
            if (n_sh_reg[0]) begin
                acc_reg <= acc_reg + lo_sh_reg;
                den_reg <= den_reg + rng_sh_reg;
            end
            n_sh_reg   <= n_sh_reg >> 1;
            lo_sh_reg  <= lo_sh_reg << 1;
            rng_sh_reg <= rng_sh_reg << 1;
        end
        if (prep_en) begin
            a_reg   <= {mag, {FRAC_BITS{1'b0}}};
            neg_reg <= diff[MAG_W];
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        if (div_en) begin
            a_reg   <= a_reg << 1;
            rem_reg <= rem_next;
            q_reg   <= {q_reg[LEVEL_BITS-2:0], ge};
            ovf_reg <= ovf_reg | q_reg[LEVEL_BITS-1];
        end
        if (fin_en) begin
            level_reg <= level_next;
        end
    end

    assign done  = done_reg;
    assign level = level_reg;

endmodule

FILE: verif/tb_top.sv
// Self-checking bench for centered_moving_average_norm: random records of sample pairs,
// a scoreboard of predicted Q8.8 levels, and register writes between phases.
// Depends on rtl/cman_pkg.sv, rtl/centered_moving_average_norm.sv and rtl/cman_norm.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cman_pkg::*;

    localparam int WIN            = WINDOW_DEF;
    localparam int HALF           = WIN / 2;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int CFG_MAX        = (1 << CFG_BITS) - 1;
    localparam longint LEVEL_MAX  = (1 << (LEVEL_BITS - 1)) - 1;
    localparam longint LEVEL_MIN  = -(1 << (LEVEL_BITS - 1));
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 50;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_SPARE = CFG_FLX_HIGH + 1'b1;

    logic                    aclk      = 1'b1;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    cman_in_t                s_data    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    cman_out_t               m_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_data  = '0;

    centered_moving_average_norm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // predictor state: sample rings, running sums and register copies
    logic [SAMPLE_BITS-1:0] ext_ring [WIN];
    logic [SAMPLE_BITS-1:0] flx_ring [WIN];
    int unsigned            ext_acc, flx_acc, held, head;
    logic [CFG_BITS-1:0]    ext_lo_r, ext_hi_r, flx_lo_r, flx_hi_r;

    cman_in_t    sample_q[$];
    cman_out_t   pending_levels[$];
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;
    logic        s_taken      = 1'b0;
    logic        cfg_taken    = 1'b0;

    // (sum - lo*n) / (n*(hi-lo)) in Q8.8, truncated toward zero, then saturated
    function automatic logic signed [LEVEL_BITS-1:0] to_level(int unsigned acc, int unsigned n,
                                                             logic [CFG_BITS-1:0] lo,
                                                             logic [CFG_BITS-1:0] hi);
        longint num, den, q;
        if (hi <= lo || n == 0)
            return LEVEL_MAX[LEVEL_BITS-1:0];
        num = (longint'(acc) - longint'(lo) * longint'(n)) * 256;
        den = longint'(n) * (longint'(hi) - longint'(lo));
        q = num / den;
        if (q > LEVEL_MAX)
            q = LEVEL_MAX;
        else if (q < LEVEL_MIN)
            q = LEVEL_MIN;
        return q[LEVEL_BITS-1:0];
    endfunction

    function automatic void push_level(int unsigned n, logic fin);
        pending_levels.push_back('{ext_level: to_level(ext_acc, n, ext_lo_r, ext_hi_r),
                                   flx_level: to_level(flx_acc, n, flx_lo_r, flx_hi_r),
                                   final_out: fin});
    endfunction

    function automatic void clear_record();
        ext_acc = 0;
        flx_acc = 0;
        held    = 0;
        head    = 0;
    endfunction

    function automatic void smooth_and_scale(cman_in_t it);
        int unsigned slot;
        if (held < WIN) begin
            ext_ring[held] = it.ext_mag;
            flx_ring[held] = it.flx_mag;
            ext_acc += it.ext_mag;
            flx_acc += it.flx_mag;
            held++;
            // record ended before the window filled: a single average, no tail
            if (it.record_end && held < WIN) begin
                push_level(held, 1'b1);
                clear_record();
                return;
            end
            if (held >= HALF)
                push_level(held, it.record_end && HALF < 2);
        end else begin
            slot = head;
            ext_acc -= ext_ring[slot];
            flx_acc -= flx_ring[slot];
            ext_ring[slot] = it.ext_mag;
            flx_ring[slot] = it.flx_mag;
            ext_acc += it.ext_mag;
            flx_acc += it.flx_mag;
            head = (slot + 1) % WIN;
            push_level(WIN, it.record_end && HALF < 2);
        end
        if (it.record_end) begin
            // tail: drop the oldest sample each time, divisor shrinks with it
            for (int t = 0; t + 1 < HALF; t++) begin
                slot = (head + t) % WIN;
                ext_acc -= ext_ring[slot];
                flx_acc -= flx_ring[slot];
                push_level(WIN - t - 1, t + 2 == HALF);
            end
            clear_record();
        end
    endfunction

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= sample_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        cman_out_t want;
        s_taken   <= s_valid && s_ready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (!aresetn) begin
            ext_lo_r = EXT_LOW_RST;
            ext_hi_r = EXT_HIGH_RST;
            flx_lo_r = FLX_LOW_RST;
            flx_hi_r = FLX_HIGH_RST;
            clear_record();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_levels.size() == 0) begin
                    $error("unexpected result: ext_level %0d flx_level %0d final_out %0b",
                           m_data.ext_level, m_data.flx_level, m_data.final_out);
                    fail_count++;
                end else begin
                    want = pending_levels.pop_front();
                    if (m_data.ext_level !== want.ext_level) begin
                        $error("ext_level: expected %0d, got %0d",
                               want.ext_level, m_data.ext_level);
                        fail_count++;
                    end
                    if (m_data.flx_level !== want.flx_level) begin
                        $error("flx_level: expected %0d, got %0d",
                               want.flx_level, m_data.flx_level);
                        fail_count++;
                    end
                    if (m_data.final_out !== want.final_out) begin
                        $error("final_out: expected %0b, got %0b",
                               want.final_out, m_data.final_out);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_EXT_LOW:  ext_lo_r = cfg_data;
                    CFG_EXT_HIGH: ext_hi_r = cfg_data;
                    CFG_FLX_LOW:  flx_lo_r = cfg_data;
                    CFG_FLX_HIGH: flx_hi_r = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                smooth_and_scale(s_data);
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void push_sample(logic [SAMPLE_BITS-1:0] e, logic [SAMPLE_BITS-1:0] f,
                                        logic last);
        sample_q.push_back('{ext_mag: e, flx_mag: f, record_end: last});
    endfunction

    // mostly between the two levels so the result stays in range, some extremes
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [CFG_BITS-1:0] a,
                                                           logic [CFG_BITS-1:0] b);
        int unsigned lo, hi, r;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        r  = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 16)
            return SAMPLE_BITS'(SAMPLE_MAX);
        if (r < 40)
            return SAMPLE_BITS'($urandom_range(SAMPLE_MAX, 0));
        return SAMPLE_BITS'($urandom_range(hi, lo));
    endfunction

    task automatic set_idle(int unsigned tx, int unsigned rx);
        @(posedge aclk);
        tx_idle_pct = tx;
        rx_idle_pct = rx;
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_levels(int unsigned el, int unsigned eh, int unsigned fl, int unsigned fh);
        write_reg(CFG_EXT_LOW, CFG_BITS'(el));
        write_reg(CFG_EXT_HIGH, CFG_BITS'(eh));
        write_reg(CFG_FLX_LOW, CFG_BITS'(fl));
        write_reg(CFG_FLX_HIGH, CFG_BITS'(fh));
    endtask

    // whole records: mostly full windows and longer, some short ones
    task automatic run_records(int unsigned target);
        int unsigned count, len, r;
        @(posedge aclk);
        count = 0;
        while (count < target) begin
            r = $urandom_range(99);
            if (r < 20)
                len = $urandom_range(WIN - 1, 1);
            else if (r < 35)
                len = WIN;
            else
                len = $urandom_range(3 * WIN, WIN + 1);
            for (int i = 0; i < len; i++)
                push_sample(pick_sample(ext_lo_r, ext_hi_r), pick_sample(flx_lo_r, flx_hi_r),
                            i == len - 1);
            count += len;
        end
    endtask

    // wait until every sample has been sent and every predicted level has come back
    task automatic drain();
        do @(posedge aclk);
        while (sample_q.size() != 0 || s_valid || pending_levels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned el, fl;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset levels: short records, then one exact window with extremes
        set_idle(15, 83);
        push_sample(SAMPLE_BITS'(SAMPLE_MAX), '0, 1'b1);
        push_sample('0, SAMPLE_BITS'(17), 1'b0);
        push_sample(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(49), 1'b0);
        push_sample(SAMPLE_BITS'(1), SAMPLE_BITS'(33), 1'b1);
        for (int i = 0; i < WIN; i++)
            push_sample(SAMPLE_BITS'((i % 2) ? 0 : SAMPLE_MAX),
                        SAMPLE_BITS'((i < HALF) ? i * 4 : SAMPLE_MAX), i == WIN - 1);
        drain();

        // high below low on extensor, one-code span on flexor
        set_levels(CFG_MAX, 0, CFG_MAX - 1, CFG_MAX);
        run_records(PHASE_ITEMS);
        drain();

        set_idle(83, 15);
        el = $urandom_range(CFG_MAX / 2);
        fl = $urandom_range(CFG_MAX / 2);
        set_levels(el, $urandom_range(CFG_MAX, el + 1), fl, $urandom_range(CFG_MAX, fl + 1));
        run_records(PHASE_ITEMS);
        drain();

        set_levels(0, CFG_MAX, 0, CFG_MAX);
        run_records(PHASE_ITEMS);
        drain();

        // equal levels saturate positive; spare indexes must leave registers alone
        set_idle(0, 0);
        el = $urandom_range(CFG_MAX);
        fl = $urandom_range(CFG_MAX - 1);
        set_levels(el, el, fl, fl + 1);
        write_reg(CFG_IDX_BITS'($urandom_range((1 << CFG_IDX_BITS) - 1, CFG_FIRST_SPARE)),
                  CFG_BITS'($urandom_range(CFG_MAX)));
        write_reg(CFG_IDX_BITS'($urandom_range((1 << CFG_IDX_BITS) - 1, CFG_FIRST_SPARE)),
                  CFG_BITS'($urandom_range(CFG_MAX)));
        run_records(PHASE_ITEMS);
        drain();

        set_levels($urandom_range(CFG_MAX), $urandom_range(CFG_MAX),
                   $urandom_range(CFG_MAX), $urandom_range(CFG_MAX));
        run_records(PHASE_ITEMS);
        drain();

        if (fail_count == 0 && pending_levels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
